>>> rtl/core/sliding_wavelet_denoiser_defines.svh
// Assertion macros for the checker file of the denoiser.
`ifndef SLIDING_WAVELET_DENOISER_DEFINES_SVH
`define SLIDING_WAVELET_DENOISER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swd checker: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swd checker: property failed");

`endif

>>> rtl/core/swd_pkg.sv
package swd_pkg;

	localparam int WINDOW_SIZE_DEF = 64;
	localparam int MAX_LEVELS_DEF  = 3;
	localparam int FILTER_TAPS     = 8;
	localparam int TAP_W           = 3;

	localparam int SAMPLE_W   = 16;
	localparam int DATA_W     = 32;
	localparam int COEF_W     = 16;
	localparam int PROD_W     = DATA_W + COEF_W;
	localparam int ACC_W      = PROD_W + 4;
	localparam int THR_W      = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam int LEVELS_W   = 3;
	localparam int ADDR_MAX_W = 8;

	localparam int LEVELS_RESET = 1;
	localparam int THR_RESET    = 256;
	localparam int ROUND_SHIFT  = 15;
	localparam int ROUND_BIAS   = 16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEVELS    = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_MODE      = 2'd2
	} cfg_reg_e;

	typedef enum logic {
		MODE_HARD = 1'b0,
		MODE_SOFT = 1'b1
	} thr_mode_e;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DEC,
		ST_MOVE,
		ST_COPY,
		ST_REC,
		ST_READ_OUT,
		ST_DRAIN,
		ST_FINISH
	} state_e;

	typedef enum logic [1:0] {
		SRC_RING,
		SRC_WORK,
		SRC_APPROX,
		SRC_DETAIL
	} src_e;

	typedef enum logic [1:0] {
		BANK_DEC_LOW,
		BANK_DEC_HIGH,
		BANK_REC_LOW,
		BANK_REC_HIGH
	} bank_e;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_MOVE,
		OP_MAC,
		OP_OUT
	} kind_e;

	typedef enum logic [1:0] {
		DST_WORK,
		DST_APPROX,
		DST_DETAIL,
		DST_PAIR
	} dst_e;

	// One datapath operation, issued by the controller in the cycle its read address is valid.
	typedef struct packed {
		kind_e                 kind;
		src_e                  src;
		bank_e                 bank;
		logic [TAP_W-1:0]      tap;
		logic                  acc_hi;
		logic                  first;
		logic                  last;
		logic                  thr;
		dst_e                  dst;
		logic [ADDR_MAX_W-1:0] rd_addr;
		logic [ADDR_MAX_W-1:0] wr_addr;
	} cmd_t;

	typedef struct packed {
		logic                  ring_we;
		logic [ADDR_MAX_W-1:0] ring_waddr;
		logic                  out_load;
		logic                  out_pass;
	} ctl_t;

	typedef logic signed [COEF_W-1:0] coef_arr_t [FILTER_TAPS];

	localparam coef_arr_t DEC_LOW  = '{-16'sd347, 16'sd1078, 16'sd1011, -16'sd6129,
		-16'sd917, 16'sd20673, 16'sd23424, 16'sd7549};
	localparam coef_arr_t DEC_HIGH = '{-16'sd7549, 16'sd23424, -16'sd20673, -16'sd917,
		16'sd6129, 16'sd1011, -16'sd1078, -16'sd347};
	localparam coef_arr_t REC_LOW  = '{16'sd7549, 16'sd23424, 16'sd20673, -16'sd917,
		-16'sd6129, 16'sd1011, 16'sd1078, -16'sd347};
	localparam coef_arr_t REC_HIGH = '{-16'sd347, -16'sd1078, 16'sd1011, 16'sd6129,
		-16'sd917, -16'sd20673, 16'sd23424, -16'sd7549};

	function automatic logic signed [COEF_W-1:0] coef_lookup(bank_e bank, logic [TAP_W-1:0] tap);
		logic signed [COEF_W-1:0] c;
		unique case (bank)
			BANK_DEC_LOW:  c = DEC_LOW[tap];
			BANK_DEC_HIGH: c = DEC_HIGH[tap];
			BANK_REC_LOW:  c = REC_LOW[tap];
			BANK_REC_HIGH: c = REC_HIGH[tap];
			default:       c = '0;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/core/swd_if.sv
interface swd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [swd_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface swd_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [swd_pkg::SAMPLE_W-1:0] denoised_sample;
	logic                                 passed_through;

	modport source (output valid, output denoised_sample, output passed_through, input ready);
	modport sink (input valid, input denoised_sample, input passed_through, output ready);
endinterface

>>> rtl/core/sliding_wavelet_denoiser.sv
// Sliding-window db4 wavelet denoiser. Every accepted sample (signed Q7.8) is written into a
// ring of WINDOW_SIZE entries and gives exactly one result. Until the ring has been filled once,
// and whenever WINDOW_SIZE is smaller than 8 << decomposition_levels, the sample comes back
// unchanged with passed_through set. Otherwise the window is copied out oldest first,
// decomposed circularly for decomposition_levels levels, the detail coefficients are
// thresholded (hard or soft), the signal is rebuilt and the middle window entry is returned,
// saturated to 16 bits. All filter arithmetic runs through one shared multiply-accumulate unit
// fed from registered-read memories. One item is in work at a time; the next sample is taken as
// soon as the result sits in the output register, even while that result still waits for its
// transfer. Configuration is written through cfg_we / cfg_index / cfg_data; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// decomposition_levels clamps to the range one to MAX_LEVELS. No memory needs clearing after
// reset.
module sliding_wavelet_denoiser #(
	parameter int WINDOW_SIZE = swd_pkg::WINDOW_SIZE_DEF,
	parameter int MAX_LEVELS  = swd_pkg::MAX_LEVELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	swd_in_if.sink                          din,
	swd_out_if.source                       dout,
	input  logic                            cfg_we,
	input  logic [swd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swd_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [swd_pkg::LEVELS_W-1:0] levels_q, levels_wr;
	logic [swd_pkg::THR_W-1:0]    thr_value_q;
	logic                         thr_mode_q;
	swd_pkg::cmd_t                cmd;
	swd_pkg::ctl_t                ctl;

	// Level writes clamp to the supported range.
	always_comb begin
		if (cfg_data == '0) begin
			levels_wr = swd_pkg::LEVELS_W'(1);
		end else if (cfg_data > swd_pkg::CFG_DATA_W'(MAX_LEVELS)) begin
			levels_wr = swd_pkg::LEVELS_W'(MAX_LEVELS);
		end else begin
			levels_wr = cfg_data[swd_pkg::LEVELS_W-1:0];
		end
	end

	// Writes to an index past the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q    <= swd_pkg::LEVELS_W'(swd_pkg::LEVELS_RESET);
			thr_value_q <= swd_pkg::THR_W'(swd_pkg::THR_RESET);
			thr_mode_q  <= swd_pkg::MODE_SOFT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swd_pkg::CFG_LEVELS:    levels_q    <= levels_wr;
				swd_pkg::CFG_THRESHOLD: thr_value_q <= cfg_data[swd_pkg::THR_W-1:0];
				swd_pkg::CFG_MODE:      thr_mode_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	swd_ctrl #(.WINDOW_SIZE(WINDOW_SIZE)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_ready (dout.ready),
		.out_valid (dout.valid),
		.levels    (levels_q),
		.cmd       (cmd),
		.ctl       (ctl)
	);

	swd_dp #(.WINDOW_SIZE(WINDOW_SIZE)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.ctl        (ctl),
		.sample     (din.sample),
		.thr_value  (thr_value_q),
		.thr_mode   (thr_mode_q),
		.out_sample (dout.denoised_sample),
		.out_passed (dout.passed_through)
	);

endmodule

>>> rtl/core/swd_ram.sv
module swd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/swd_ctrl.sv
module swd_ctrl #(
	parameter int WINDOW_SIZE = swd_pkg::WINDOW_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          out_ready,
	output logic                          out_valid,
	input  logic [swd_pkg::LEVELS_W-1:0] levels,
	output swd_pkg::cmd_t                 cmd,
	output swd_pkg::ctl_t                 ctl
);

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam int FW = $clog2(WINDOW_SIZE + 1);
	localparam int AMW = swd_pkg::ADDR_MAX_W;
	localparam logic [3:0] DEC_OPS_LAST = 4'd15;
	localparam logic [2:0] REC_OPS_LAST = 3'd7;
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	swd_pkg::state_e state_q, state_d, ret_q, ret_d;
	logic [1:0]                   drain_q, drain_d;
	logic [AW-1:0]                i_q, i_d, base_q, base_d, rp_q, rp_d, wp_q, wp_d;
	logic [3:0]                   n_q, n_d;
	logic [FW-1:0]                fill_q, fill_d;
	logic [swd_pkg::LEVELS_W-1:0] lvl_q, lvl_d;
	logic                         pass_q, pass_d, out_valid_q, out_valid_d;

	logic [AW:0]   len_c, half_c, full_c, i_ext, sum_c, addr_c, jx_c, diff_c;
	logic [AW-1:0] wp_inc, rp_inc;
	logic [2:0]    jv_c;
	logic          too_short;

	assign out_valid = out_valid_q;

	assign len_c  = (AW + 1)'(WINDOW_SIZE) >> lvl_q;
	assign half_c = len_c >> 1;
	assign full_c = {half_c[AW-1:0], 1'b0};
	assign i_ext  = {1'b0, i_q};
	assign wp_inc = (wp_q == AW'(WINDOW_SIZE - 1)) ? '0 : wp_q + 1'b1;
	assign rp_inc = (rp_q == AW'(WINDOW_SIZE - 1)) ? '0 : rp_q + 1'b1;
	assign too_short = (((AW + 1)'(WINDOW_SIZE) >> levels) < (AW + 1)'(swd_pkg::FILTER_TAPS));

	// Circular tap address for decomposition.
	assign sum_c  = {1'b0, base_q} + (AW + 1)'(n_q[3:1]);
	assign addr_c = (sum_c >= len_c) ? sum_c - len_c : sum_c;

	// Gather form of reconstruction: tap j of coefficient pair i lands on k = (2i + j) mod full.
	assign jv_c   = {n_q[2:1], i_q[0]};
	assign jx_c   = (AW + 1)'(jv_c);
	assign diff_c = (i_ext >= jx_c) ? i_ext - jx_c : i_ext + full_c - jx_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swd_pkg::ST_IDLE;
			ret_q       <= swd_pkg::ST_IDLE;
			drain_q     <= '0;
			i_q         <= '0;
			n_q         <= '0;
			base_q      <= '0;
			rp_q        <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			lvl_q       <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			drain_q     <= drain_d;
			i_q         <= i_d;
			n_q         <= n_d;
			base_q      <= base_d;
			rp_q        <= rp_d;
			wp_q        <= wp_d;
			fill_q      <= fill_d;
			lvl_q       <= lvl_d;
			pass_q      <= pass_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ret_d       = ret_q;
		drain_d     = drain_q;
		i_d         = i_q;
		n_d         = n_q;
		base_d      = base_q;
		rp_d        = rp_q;
		wp_d        = wp_q;
		fill_d      = fill_q;
		lvl_d       = lvl_q;
		pass_d      = pass_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		ctl         = '0;
		in_ready    = 1'b0;

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			swd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.ring_we    = 1'b1;
					ctl.ring_waddr = AMW'(wp_q);
					wp_d = wp_inc;
					rp_d = wp_inc;
					i_d  = '0;
					n_d  = '0;
					if ((fill_q < FW'(WINDOW_SIZE)) || too_short) begin
						pass_d = 1'b1;
						if (fill_q < FW'(WINDOW_SIZE)) begin
							fill_d = fill_q + 1'b1;
						end
						state_d = swd_pkg::ST_FINISH;
					end else begin
						pass_d  = 1'b0;
						state_d = swd_pkg::ST_LOAD;
					end
				end
			end
			swd_pkg::ST_LOAD: begin
				cmd.kind    = swd_pkg::OP_MOVE;
				cmd.src     = swd_pkg::SRC_RING;
				cmd.dst     = swd_pkg::DST_WORK;
				cmd.rd_addr = AMW'(rp_q);
				cmd.wr_addr = AMW'(i_q);
				rp_d = rp_inc;
				i_d  = i_q + 1'b1;
				if (i_q == AW'(WINDOW_SIZE - 1)) begin
					i_d     = '0;
					n_d     = '0;
					base_d  = '0;
					lvl_d   = '0;
					ret_d   = swd_pkg::ST_DEC;
					drain_d = '0;
					state_d = swd_pkg::ST_DRAIN;
				end
			end
			swd_pkg::ST_DEC: begin
				cmd.kind    = swd_pkg::OP_MAC;
				cmd.src     = swd_pkg::SRC_WORK;
				cmd.bank    = n_q[0] ? swd_pkg::BANK_DEC_HIGH : swd_pkg::BANK_DEC_LOW;
				cmd.tap     = n_q[3:1];
				cmd.acc_hi  = n_q[0];
				cmd.first   = (n_q[3:1] == '0);
				cmd.last    = (n_q == DEC_OPS_LAST);
				cmd.dst     = swd_pkg::DST_PAIR;
				cmd.rd_addr = AMW'(addr_c);
				cmd.wr_addr = AMW'(i_q);
				n_d = n_q + 1'b1;
				if (n_q == DEC_OPS_LAST) begin
					i_d    = i_q + 1'b1;
					base_d = base_q + 2'd2;
					if (i_ext == half_c - 1'b1) begin
						i_d     = '0;
						base_d  = '0;
						ret_d   = swd_pkg::ST_MOVE;
						drain_d = '0;
						state_d = swd_pkg::ST_DRAIN;
					end
				end
			end
			swd_pkg::ST_MOVE: begin
				cmd.kind    = swd_pkg::OP_MOVE;
				cmd.dst     = swd_pkg::DST_WORK;
				cmd.rd_addr = AMW'(i_q);
				if (n_q[0]) begin
					cmd.src     = swd_pkg::SRC_DETAIL;
					cmd.thr     = 1'b1;
					cmd.wr_addr = AMW'(half_c + i_ext);
					n_d = '0;
					i_d = i_q + 1'b1;
					if (i_ext == half_c - 1'b1) begin
						i_d = '0;
						if (lvl_q + 1'b1 < levels) begin
							lvl_d = lvl_q + 1'b1;
							ret_d = swd_pkg::ST_DEC;
						end else begin
							ret_d = swd_pkg::ST_COPY;
						end
						drain_d = '0;
						state_d = swd_pkg::ST_DRAIN;
					end
				end else begin
					cmd.src     = swd_pkg::SRC_APPROX;
					cmd.wr_addr = AMW'(i_q);
					n_d = 4'd1;
				end
			end
			swd_pkg::ST_COPY: begin
				cmd.kind    = swd_pkg::OP_MOVE;
				cmd.src     = swd_pkg::SRC_WORK;
				cmd.wr_addr = AMW'(i_q);
				if (n_q[0]) begin
					cmd.dst     = swd_pkg::DST_DETAIL;
					cmd.rd_addr = AMW'(half_c + i_ext);
					n_d = '0;
					i_d = i_q + 1'b1;
					if (i_ext == half_c - 1'b1) begin
						i_d     = '0;
						ret_d   = swd_pkg::ST_REC;
						drain_d = '0;
						state_d = swd_pkg::ST_DRAIN;
					end
				end else begin
					cmd.dst     = swd_pkg::DST_APPROX;
					cmd.rd_addr = AMW'(i_q);
					n_d = 4'd1;
				end
			end
			swd_pkg::ST_REC: begin
				cmd.kind    = swd_pkg::OP_MAC;
				cmd.src     = n_q[0] ? swd_pkg::SRC_DETAIL : swd_pkg::SRC_APPROX;
				cmd.bank    = n_q[0] ? swd_pkg::BANK_REC_HIGH : swd_pkg::BANK_REC_LOW;
				cmd.tap     = jv_c;
				cmd.first   = (n_q[2:0] == '0);
				cmd.last    = (n_q[2:0] == REC_OPS_LAST);
				cmd.dst     = swd_pkg::DST_WORK;
				cmd.rd_addr = AMW'(diff_c >> 1);
				cmd.wr_addr = AMW'(i_q);
				n_d = n_q + 1'b1;
				if (n_q[2:0] == REC_OPS_LAST) begin
					n_d = '0;
					i_d = i_q + 1'b1;
					if (i_ext == full_c - 1'b1) begin
						i_d = '0;
						if (lvl_q == '0) begin
							ret_d = swd_pkg::ST_READ_OUT;
						end else begin
							lvl_d = lvl_q - 1'b1;
							ret_d = swd_pkg::ST_COPY;
						end
						drain_d = '0;
						state_d = swd_pkg::ST_DRAIN;
					end
				end
			end
			swd_pkg::ST_READ_OUT: begin
				cmd.kind    = swd_pkg::OP_OUT;
				cmd.src     = swd_pkg::SRC_WORK;
				cmd.rd_addr = AMW'(WINDOW_SIZE / 2);
				ret_d   = swd_pkg::ST_FINISH;
				drain_d = '0;
				state_d = swd_pkg::ST_DRAIN;
			end
			swd_pkg::ST_DRAIN: begin
				if (drain_q == DRAIN_LAST) begin
					state_d = ret_q;
				end else begin
					drain_d = drain_q + 1'b1;
				end
			end
			swd_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					ctl.out_pass = pass_q;
					out_valid_d  = 1'b1;
					state_d      = swd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/swd_dp.sv
module swd_dp #(
	parameter int WINDOW_SIZE = swd_pkg::WINDOW_SIZE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  swd_pkg::cmd_t                        cmd,
	input  swd_pkg::ctl_t                        ctl,
	input  logic signed [swd_pkg::SAMPLE_W-1:0] sample,
	input  logic [swd_pkg::THR_W-1:0]           thr_value,
	input  logic                                 thr_mode,
	output logic signed [swd_pkg::SAMPLE_W-1:0] out_sample,
	output logic                                 out_passed
);

	localparam int AW  = $clog2(WINDOW_SIZE);
	localparam int HAW = $clog2(WINDOW_SIZE / 2);
	localparam int DW  = swd_pkg::DATA_W;
	localparam int SW  = swd_pkg::SAMPLE_W;
	localparam int PW  = swd_pkg::PROD_W;
	localparam int CW  = swd_pkg::ACC_W;
	localparam int RW  = CW - swd_pkg::ROUND_SHIFT;

	function automatic logic [DW-1:0] round_sat(logic signed [CW-1:0] acc);
		logic signed [CW-1:0] x;
		logic signed [RW-1:0] r;
		logic [DW-1:0]        res;
		// Floor of (acc + half) / 2^15, then clamp to 32 bits.
		x = acc + CW'(swd_pkg::ROUND_BIAS);
		r = RW'(x >>> swd_pkg::ROUND_SHIFT);
		if ((&r[RW-1:DW-1]) || !(|r[RW-1:DW-1])) begin
			res = r[DW-1:0];
		end else begin
			res = r[RW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end
		return res;
	endfunction

	function automatic logic [SW-1:0] sat16(logic [DW-1:0] v);
		logic [SW-1:0] res;
		if ((&v[DW-1:SW-1]) || !(|v[DW-1:SW-1])) begin
			res = v[SW-1:0];
		end else begin
			res = v[DW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end
		return res;
	endfunction

	function automatic logic [DW-1:0] threshold(logic [DW-1:0] v,
		logic [swd_pkg::THR_W-1:0] t, logic mode);
		logic signed [DW:0] vx, mag, tx, d;
		logic [DW-1:0]      res;
		vx  = (DW + 1)'(signed'(v));
		mag = v[DW-1] ? -vx : vx;
		tx  = signed'({{(DW + 1 - swd_pkg::THR_W){1'b0}}, t});
		d   = mag - tx;
		if (mag <= tx) begin
			res = '0;
		end else if (mode == swd_pkg::MODE_SOFT) begin
			res = v[DW-1] ? DW'(-d) : DW'(d);
		end else begin
			res = v;
		end
		return res;
	endfunction

	swd_pkg::cmd_t cmd_s1, cmd_s2, cmd_s3;

	logic [SW-1:0] ring_rdata;
	logic [DW-1:0] work_rdata, approx_rdata, detail_rdata;
	logic          work_we, approx_we, detail_we;
	logic [DW-1:0] work_wdata, approx_wdata, detail_wdata;

	logic signed [DW-1:0]               op_s1;
	logic signed [swd_pkg::COEF_W-1:0] coef_s1;
	logic signed [PW-1:0]               prod_s2;
	logic [DW-1:0]                      op_s2, mv_s3;
	logic signed [CW-1:0]               acc_lo_q, acc_hi_q, acc_in, acc_sum;
	logic [DW-1:0]                      rnd_lo, rnd_hi;
	logic [SW-1:0]                      res_q, sample_q, out_data_q;
	logic                               out_pass_q;

	swd_ram #(.WIDTH(SW), .DEPTH(WINDOW_SIZE)) u_ring (
		.clk   (clk),
		.we    (ctl.ring_we),
		.waddr (ctl.ring_waddr[AW-1:0]),
		.wdata (sample),
		.raddr (cmd.rd_addr[AW-1:0]),
		.rdata (ring_rdata)
	);

	swd_ram #(.WIDTH(DW), .DEPTH(WINDOW_SIZE)) u_work (
		.clk   (clk),
		.we    (work_we),
		.waddr (cmd_s3.wr_addr[AW-1:0]),
		.wdata (work_wdata),
		.raddr (cmd.rd_addr[AW-1:0]),
		.rdata (work_rdata)
	);

	swd_ram #(.WIDTH(DW), .DEPTH(WINDOW_SIZE / 2)) u_approx (
		.clk   (clk),
		.we    (approx_we),
		.waddr (cmd_s3.wr_addr[HAW-1:0]),
		.wdata (approx_wdata),
		.raddr (cmd.rd_addr[HAW-1:0]),
		.rdata (approx_rdata)
	);

	swd_ram #(.WIDTH(DW), .DEPTH(WINDOW_SIZE / 2)) u_detail (
		.clk   (clk),
		.we    (detail_we),
		.waddr (cmd_s3.wr_addr[HAW-1:0]),
		.wdata (detail_wdata),
		.raddr (cmd.rd_addr[HAW-1:0]),
		.rdata (detail_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			cmd_s2 <= '0;
			cmd_s3 <= '0;
		end else begin
			cmd_s1 <= cmd;
			cmd_s2 <= cmd_s1;
			cmd_s3 <= cmd_s2;
		end
	end

	always_comb begin
		case (cmd_s1.src)
			swd_pkg::SRC_RING:   op_s1 = DW'(signed'(ring_rdata));
			swd_pkg::SRC_WORK:   op_s1 = signed'(work_rdata);
			swd_pkg::SRC_APPROX: op_s1 = signed'(approx_rdata);
			default:             op_s1 = signed'(detail_rdata);
		endcase
		coef_s1 = swd_pkg::coef_lookup(cmd_s1.bank, cmd_s1.tap);
	end

	// Stage 2: the one shared multiplier.
	always_ff @(posedge clk) begin
		prod_s2 <= op_s1 * coef_s1;
		op_s2   <= op_s1;
	end

	assign acc_in  = cmd_s2.acc_hi ? acc_hi_q : acc_lo_q;
	assign acc_sum = cmd_s2.first ? CW'(prod_s2) : acc_in + CW'(prod_s2);

	// Stage 3: accumulate, or pass the operand on, through the threshold when the command asks for it.
	always_ff @(posedge clk) begin
		if (cmd_s2.kind == swd_pkg::OP_MAC) begin
			if (cmd_s2.acc_hi) begin
				acc_hi_q <= acc_sum;
			end else begin
				acc_lo_q <= acc_sum;
			end
		end
		mv_s3 <= cmd_s2.thr ? threshold(op_s2, thr_value, thr_mode) : op_s2;
	end

	assign rnd_lo = round_sat(acc_lo_q);
	assign rnd_hi = round_sat(acc_hi_q);

	always_comb begin
		work_we      = 1'b0;
		approx_we    = 1'b0;
		detail_we    = 1'b0;
		work_wdata   = mv_s3;
		approx_wdata = mv_s3;
		detail_wdata = mv_s3;
		if (cmd_s3.kind == swd_pkg::OP_MOVE) begin
			work_we   = (cmd_s3.dst == swd_pkg::DST_WORK);
			approx_we = (cmd_s3.dst == swd_pkg::DST_APPROX);
			detail_we = (cmd_s3.dst == swd_pkg::DST_DETAIL);
		end else if (cmd_s3.kind == swd_pkg::OP_MAC && cmd_s3.last) begin
			work_wdata   = rnd_lo;
			approx_wdata = rnd_lo;
			detail_wdata = rnd_hi;
			work_we      = (cmd_s3.dst == swd_pkg::DST_WORK);
			approx_we    = (cmd_s3.dst == swd_pkg::DST_PAIR);
			detail_we    = (cmd_s3.dst == swd_pkg::DST_PAIR);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_s3.kind == swd_pkg::OP_OUT) begin
			res_q <= sat16(mv_s3);
		end
		if (ctl.ring_we) begin
			sample_q <= sample;
		end
		if (ctl.out_load) begin
			out_data_q <= ctl.out_pass ? sample_q : res_q;
			out_pass_q <= ctl.out_pass;
		end
	end

	assign out_sample = signed'(out_data_q);
	assign out_passed = out_pass_q;

endmodule

>>> rtl/core/swd_checker.sv
`include "sliding_wavelet_denoiser_defines.svh"

module swd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [swd_pkg::SAMPLE_W-1:0]  out_sample,
	input logic                           out_passed
);

	// A stalled result stays offered.
	`SWD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// A stalled result keeps its payload.
	`SWD_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_sample) && $stable(out_passed))

	// One sample is in work at a time: input closes right after a transfer.
	`SWD_ASSERT_NEXT(a_in_closes, clk, arst_n, in_valid && in_ready, !in_ready)

	// A result never appears in the cycle right after an input transfer.
	`SWD_ASSERT_NEXT(a_no_instant_out, clk, arst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

bind sliding_wavelet_denoiser swd_checker u_swd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (din.valid),
	.in_ready   (din.ready),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.out_sample (dout.denoised_sample),
	.out_passed (dout.passed_through)
);

>>> tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN  = swd_pkg::WINDOW_SIZE_DEF;
	localparam int HALF = WIN / 2;

	// One expected output transfer.
	typedef struct {
		logic signed [swd_pkg::SAMPLE_W-1:0] value;
		logic                                pass;
	} denoised_t;

	// One row of the directed table. When typed is set, the value and pass flag
	// written here replace the model's prediction in the check.
	typedef struct {
		logic signed [swd_pkg::SAMPLE_W-1:0] sample;
		bit                                  typed;
		logic signed [swd_pkg::SAMPLE_W-1:0] value;
		logic                                pass;
	} row_t;

	// One configuration setting; levels is the raw value written, before the
	// block clamps it.
	typedef struct {
		int                 levels;
		int                 thr;
		swd_pkg::thr_mode_e mode;
		int                 items;
	} setting_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [swd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [swd_pkg::CFG_DATA_W-1:0] cfg_data;

	swd_in_if  din();
	swd_out_if dout();

	sliding_wavelet_denoiser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din.sink),
		.dout      (dout.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Model state: the sample ring, the working stores and the registers.
	int                 ring [WIN];
	int                 wr_ptr;
	int                 filled;
	int                 work [WIN];
	int                 approx [HALF];
	int                 detail [HALF];
	int                 levels;
	int                 thr_value;
	swd_pkg::thr_mode_e thr_mode;

	const int dec_lo [8] = '{-347, 1078, 1011, -6129, -917, 20673, 23424, 7549};
	const int dec_hi [8] = '{-7549, 23424, -20673, -917, 6129, 1011, -1078, -347};
	const int rec_lo [8] = '{7549, 23424, 20673, -917, -6129, 1011, 1078, -347};
	const int rec_hi [8] = '{-347, -1078, 1011, 6129, -917, -20673, 23424, -7549};

	denoised_t pending [$];
	int        errors;
	int        sent;
	int        received;
	int        denoised_seen;
	bit        calm;       // no idling on either side while set
	bit        hold_req;   // asks the receiver for one long hold-off

	function automatic int sat32(longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return int'(x);
	endfunction

	// Rounding to nearest, ties toward plus infinity, is a floor after adding half.
	function automatic int round_q15(longint acc);
		return sat32((acc + swd_pkg::ROUND_BIAS) >>> swd_pkg::ROUND_SHIFT);
	endfunction

	function automatic int shrink(int v);
		longint a;
		a = (v < 0) ? -longint'(v) : longint'(v);
		if (thr_mode == swd_pkg::MODE_SOFT) begin
			if (a <= thr_value) return 0;
			return sat32((v < 0) ? -(a - thr_value) : (a - thr_value));
		end
		return (a > thr_value) ? v : 0;
	endfunction

	// Advances the model by one sample and returns the output it causes.
	function automatic denoised_t denoise_step(logic signed [swd_pkg::SAMPLE_W-1:0] s);
		denoised_t r;
		int len;
		int half;
		int idx;
		int v;
		longint lo;
		longint hi;
		longint acc [WIN];
		ring[wr_ptr] = s;
		wr_ptr = (wr_ptr + 1) % WIN;
		if (filled < WIN || WIN < (8 << levels)) begin
			if (filled < WIN) filled++;
			r.value = s;
			r.pass = 1'b1;
			return r;
		end
		for (int i = 0; i < WIN; i++) work[i] = ring[(wr_ptr + i) % WIN];
		len = WIN;
		for (int l = 0; l < levels; l++) begin
			half = len / 2;
			for (int i = 0; i < half; i++) begin
				lo = 0;
				hi = 0;
				for (int j = 0; j < 8; j++) begin
					idx = (2 * i + j) % len;
					lo += longint'(work[idx]) * dec_lo[j];
					hi += longint'(work[idx]) * dec_hi[j];
				end
				approx[i] = round_q15(lo);
				detail[i] = round_q15(hi);
			end
			for (int i = 0; i < half; i++) begin
				work[half + i] = shrink(detail[i]);
				work[i] = approx[i];
			end
			len = half;
		end
		for (int l = levels - 1; l >= 0; l--) begin
			half = (WIN >> l) / 2;
			for (int i = 0; i < half; i++) begin
				approx[i] = work[i];
				detail[i] = work[half + i];
			end
			for (int k = 0; k < 2 * half; k++) acc[k] = 0;
			for (int i = 0; i < half; i++) begin
				for (int j = 0; j < 8; j++) begin
					idx = (2 * i + j) % (2 * half);
					acc[idx] += longint'(approx[i]) * rec_lo[j];
					acc[idx] += longint'(detail[i]) * rec_hi[j];
				end
			end
			for (int k = 0; k < 2 * half; k++) work[k] = round_q15(acc[k]);
		end
		v = work[WIN / 2];
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		r.value = v[swd_pkg::SAMPLE_W-1:0];
		r.pass = 1'b0;
		return r;
	endfunction

	// Free-running clock, 4 ns period.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A random sample: half the time a small signal with noise, otherwise the full range or an extreme,
	// so that the output saturates and every input bit toggles.
	function automatic logic signed [swd_pkg::SAMPLE_W-1:0] pick_sample();
		int k;
		k = $urandom_range(9);
		if (k < 4) return 16'($urandom);
		if (k == 4) return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		return $signed(16'($urandom_range(2047))) - 16'sd1024;
	endfunction

	task automatic write_reg(swd_pkg::cfg_reg_e idx, int value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[swd_pkg::CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Writes one setting while the block is idle and mirrors it in the model.
	task automatic apply_setting(setting_t st);
		write_reg(swd_pkg::CFG_LEVELS, st.levels);
		write_reg(swd_pkg::CFG_THRESHOLD, st.thr);
		write_reg(swd_pkg::CFG_MODE, st.mode);
		levels = (st.levels < 1) ? 1 :
			(st.levels > swd_pkg::MAX_LEVELS_DEF) ? swd_pkg::MAX_LEVELS_DEF : st.levels;
		thr_value = st.thr & 16'h7fff;
		thr_mode = st.mode;
	endtask

	// Offers one sample, idling at random beforehand, and records the expected
	// result once the transfer has happened. Called at a falling edge; returns
	// at the falling edge after the transfer with valid still high.
	task automatic offer(logic signed [swd_pkg::SAMPLE_W-1:0] s, bit typed,
		denoised_t typed_res);
		denoised_t r;
		while (!calm && $urandom_range(99) < 25) begin
			din.valid = 1'b0;
			@(negedge clk);
		end
		din.valid = 1'b1;
		din.sample = s;
		do @(posedge clk); while (!din.ready);
		r = denoise_step(s);
		if (typed) r = typed_res;
		pending.push_back(r);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		din.valid = 1'b0;
		while (pending.size() != 0) @(negedge clk);
	endtask

	// The receiver idles at random, except while calm, and holds off for one
	// long stretch on request so that the block fills up and stalls its input.
	initial begin
		dout.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				dout.ready = 1'b0;
				repeat (6000) @(negedge clk);
			end else begin
				dout.ready = calm || ($urandom_range(99) >= 25);
			end
		end
	end

	// Every output transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		denoised_t e;
		if (arst_n && dout.valid && dout.ready) begin
			received++;
			if (pending.size() == 0) begin
				$display("%0t: output transfer with nothing expected: value %0d pass %0b",
					$time, dout.denoised_sample, dout.passed_through);
				errors++;
			end else begin
				e = pending.pop_front();
				if (!e.pass) denoised_seen++;
				if (dout.denoised_sample !== e.value) begin
					$display("%0t: denoised_sample expected %0d actual %0d",
						$time, e.value, dout.denoised_sample);
					errors++;
				end
				if (dout.passed_through !== e.pass) begin
					$display("%0t: passed_through expected %0b actual %0b",
						$time, e.pass, dout.passed_through);
					errors++;
				end
			end
		end
	end

	// Generous limit: far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("tb_top failed");
		$finish;
	end

	row_t     rows [$];
	setting_t plan [$];

	initial begin
		denoised_t tr;
		row_t      rw;
		setting_t  st;
		int        wait_cnt;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = swd_pkg::CFG_LEVELS;
		cfg_data = '0;
		din.valid = 1'b0;
		din.sample = '0;
		errors = 0;
		sent = 0;
		received = 0;
		denoised_seen = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		foreach (ring[i]) ring[i] = 0;
		wr_ptr = 0;
		filled = 0;
		levels = swd_pkg::LEVELS_RESET;
		thr_value = swd_pkg::THR_RESET;
		thr_mode = swd_pkg::MODE_SOFT;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed rows: all fall in the filling phase, so each one must come
		// back unchanged with the pass flag set. Extremes and sign edges first.
		rows = '{
			'{16'sh7fff, 1, 16'sh7fff, 1}, '{16'sh8000, 1, 16'sh8000, 1},
			'{16'sh0000, 1, 16'sh0000, 1}, '{16'shffff, 1, 16'shffff, 1},
			'{16'sh0001, 1, 16'sh0001, 1}, '{16'sh8001, 1, 16'sh8001, 1},
			'{16'sh7ffe, 1, 16'sh7ffe, 1}, '{16'sh0100, 1, 16'sh0100, 1},
			'{16'shff00, 1, 16'shff00, 1}, '{16'sh5555, 1, 16'sh5555, 1},
			'{16'shaaaa, 1, 16'shaaaa, 1}, '{16'sh00ff, 1, 16'sh00ff, 1},
			'{16'shff01, 1, 16'shff01, 1}, '{16'sh4000, 1, 16'sh4000, 1},
			'{16'shc000, 1, 16'shc000, 1}, '{16'sh0080, 1, 16'sh0080, 1},
			'{16'sh7fff, 1, 16'sh7fff, 1}, '{16'sh8000, 1, 16'sh8000, 1},
			'{16'sh7fff, 1, 16'sh7fff, 1}, '{16'sh8000, 1, 16'sh8000, 1}
		};

		// Settings walk through every level (including clamped writes below one
		// and above the maximum), both modes and both threshold extremes.
		plan = '{
			'{0, 0, swd_pkg::MODE_HARD, 50},
			'{2, 32767, swd_pkg::MODE_SOFT, 40},
			'{7, 256, swd_pkg::MODE_HARD, 40},
			'{3, 100, swd_pkg::MODE_SOFT, 40},
			'{1, 5000, swd_pkg::MODE_HARD, 30},
			'{2, 1, swd_pkg::MODE_SOFT, 35},
			'{3, 0, swd_pkg::MODE_SOFT, 35}
		};

		foreach (plan[p]) begin
			st = plan[p];
			apply_setting(st);
			calm = (p == 3);
			if (p == 0) begin
				foreach (rows[r]) begin
					rw = rows[r];
					tr.value = rw.value;
					tr.pass = rw.pass;
					offer(rw.sample, rw.typed, tr);
				end
			end
			for (int n = 0; n < st.items; n++) begin
				// In the second setting the receiver stops for a long while
				// and the sender keeps offering, so the input backs up.
				if (p == 1 && n == 3) hold_req = 1'b1;
				offer(pick_sample(), 0, tr);
			end
			// The sender pauses until every expected result has come, so the
			// next setting is written into an idle block.
			wait_drained();
		end

		calm = 1'b0;
		wait_cnt = 0;
		while (pending.size() != 0 && wait_cnt < 200000) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (3000) @(negedge clk);
		if (pending.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending.size());
			errors += pending.size();
		end

		$display("Sent %0d samples over %0d settings; %0d results, %0d of them denoised.",
			sent, plan.size(), received, denoised_seen);
		$display("Covered levels one to three, hard and soft modes, %0d mismatches.", errors);
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/swd_pkg.sv
rtl/core/swd_if.sv
rtl/core/swd_ram.sv
rtl/core/swd_ctrl.sv
rtl/core/swd_dp.sv
rtl/core/sliding_wavelet_denoiser.sv
rtl/core/swd_checker.sv
tb/tb_top.sv
